FILE: hw/rtl/cll_pkg.sv
// Package: operation codes, status codes and shared types for the list engine.
`timescale 1ns / 1ps
package cll_pkg;

   typedef enum logic [3:0] {
      FN_CLEAR     = 4'd0,
      FN_MFRONT    = 4'd1,
      FN_MBACK     = 4'd2,
      FN_PREV      = 4'd3,
      FN_NEXT      = 4'd4,
      FN_PREPEND   = 4'd5,
      FN_APPEND    = 4'd6,
      FN_INSBEFORE = 4'd7,
      FN_INSAFTER  = 4'd8,
      FN_DELFRONT  = 4'd9,
      FN_DELBACK   = 4'd10,
      FN_DELCURSOR = 4'd11,
      FN_SET       = 4'd12,
      FN_GET       = 4'd13,
      FN_FRONT     = 4'd14,
      FN_BACK      = 4'd15
   } func_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_NOCUR = 2'd2,
      ST_FULL  = 2'd3
   } status_type;

   // memory kinds of the node store
   typedef enum logic [1:0] {
      MEM_VALUE = 2'd0,
      MEM_PREV  = 2'd1,
      MEM_NEXT  = 2'd2,
      MEM_FREE  = 2'd3
   } mem_type;

endpackage

FILE: hw/rtl/cll_node_mem.sv
// Node store: value, prev and next links and the free stack, one port each.
`timescale 1ns / 1ps
module cll_node_mem #(
   parameter int CAPACITY = 256
) (
   input  logic                         clock,
   input  logic                         val_we,
   input  logic [$clog2(CAPACITY)-1:0]  val_waddr,
   input  logic [31:0]                  val_wdata,
   input  logic [$clog2(CAPACITY)-1:0]  val_raddr,
   output logic [31:0]                  val_rdata,
   input  logic                         prv_we,
   input  logic [$clog2(CAPACITY)-1:0]  prv_waddr,
   input  logic [$clog2(CAPACITY):0]    prv_wdata,
   input  logic [$clog2(CAPACITY)-1:0]  prv_raddr,
   output logic [$clog2(CAPACITY):0]    prv_rdata,
   input  logic                         nxt_we,
   input  logic [$clog2(CAPACITY)-1:0]  nxt_waddr,
   input  logic [$clog2(CAPACITY):0]    nxt_wdata,
   input  logic [$clog2(CAPACITY)-1:0]  nxt_raddr,
   output logic [$clog2(CAPACITY):0]    nxt_rdata,
   input  logic                         fre_we,
   input  logic [$clog2(CAPACITY)-1:0]  fre_waddr,
   input  logic [$clog2(CAPACITY)-1:0]  fre_wdata,
   input  logic [$clog2(CAPACITY)-1:0]  fre_raddr,
   output logic [$clog2(CAPACITY)-1:0]  fre_rdata
);
   localparam int AW = $clog2(CAPACITY);

   logic [31:0] val_mem [CAPACITY];
   logic [AW:0] prv_mem [CAPACITY];
   logic [AW:0] nxt_mem [CAPACITY];
   logic [AW-1:0] fre_mem [CAPACITY];

   always_ff @(posedge clock) begin
      if (val_we) val_mem[val_waddr] <= val_wdata;
      if (prv_we) prv_mem[prv_waddr] <= prv_wdata;
      if (nxt_we) nxt_mem[nxt_waddr] <= nxt_wdata;
      if (fre_we) fre_mem[fre_waddr] <= fre_wdata;
      val_rdata <= val_mem[val_raddr];
      prv_rdata <= prv_mem[prv_raddr];
      nxt_rdata <= nxt_mem[nxt_raddr];
      fre_rdata <= fre_mem[fre_raddr];
   end
endmodule

FILE: hw/rtl/cursor_linked_list_engine_core.sv
// Top level: doubly linked list engine with cursor and sequencer.
//
// Usage
//   req channel: req_func selects the operation, req_value carries the element
//   for inserts and set. rsp channel: one item per request with rsp_read_value,
//   rsp_count, rsp_cursor_pos and rsp_status (0 ok, 1 empty, 2 no cursor,
//   3 pool full). Failing operations change no state.
//   After acceptance the request passes the READ state, which issues the
//   link/free-stack reads, then the registered read data, then execute.
//   A successful insert adds the link write phases (new node links, then the
//   neighbour links) before rsp_valid rises, as each link memory has a
//   single write port. A new request is taken only after the last result
//   has been taken; req_ready is low while an item is in work or its result waits.
//   Reset clears head, tail, cursor, counts and the free stack pointer; no
//   clearing pass is needed since unwritten nodes are never read.
//   A stalled receiver simply holds the result; nothing is lost.
`timescale 1ns / 1ps
module cursor_linked_list_engine_core #(
   parameter int CAPACITY = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [3:0]  req_func,
   input  logic signed [31:0] req_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic signed [31:0] rsp_read_value,
   output logic [8:0]  rsp_count,
   output logic signed [8:0] rsp_cursor_pos,
   output logic [1:0]  rsp_status
);
   localparam int AW = $clog2(CAPACITY);
   localparam logic [AW:0] NIL = (AW+1)'(CAPACITY);

   typedef enum logic [1:0] {S_IDLE, S_READ, S_EXEC, S_RESP} state_type;

   state_type state_ff;
   cll_pkg::func_type func_ff;
   logic [31:0] value_ff;
   logic [AW:0] free_top_ff, fresh_ff, head_ff, tail_ff, cur_ff, count_ff;
   logic signed [AW:0] cidx_ff;
   logic [31:0] rv_ff;
   logic [1:0]  st_ff;

   // memory ports
   logic        val_we, prv_we, nxt_we, fre_we;
   logic [AW-1:0] val_waddr, prv_waddr, nxt_waddr, fre_waddr;
   logic [31:0] val_wdata, val_rdata;
   logic [AW:0] prv_wdata, nxt_wdata, prv_rdata, nxt_rdata;
   logic [AW-1:0] fre_wdata, fre_rdata;
   logic [AW-1:0] val_raddr, prv_raddr, nxt_raddr, fre_raddr;

   cll_node_mem #(.CAPACITY(CAPACITY)) u_mem (
      .clock, .val_we, .val_waddr, .val_wdata, .val_raddr, .val_rdata,
      .prv_we, .prv_waddr, .prv_wdata, .prv_raddr, .prv_rdata,
      .nxt_we, .nxt_waddr, .nxt_wdata, .nxt_raddr, .nxt_rdata,
      .fre_we, .fre_waddr, .fre_wdata, .fre_raddr, .fre_rdata
   );

   // Node whose neighbours matter: head for delfront and front, tail for delback
   // and back, cursor otherwise.
   logic [AW:0] focus;
   always_comb begin
      case (func_ff)
         cll_pkg::FN_DELFRONT, cll_pkg::FN_FRONT: focus = head_ff;
         cll_pkg::FN_DELBACK, cll_pkg::FN_BACK:   focus = tail_ff;
         default:                                 focus = cur_ff;
      endcase
   end

   assign val_raddr = focus[AW-1:0];
   assign prv_raddr = focus[AW-1:0];
   assign nxt_raddr = focus[AW-1:0];
   assign fre_raddr = free_top_ff[AW-1:0] - AW'(1);

   // execute stage: decision and new values
   logic empty, nocur, full, do_ins, do_del, ok_ins;
   logic [AW:0] newn, ia, ib, da, db;
   logic [1:0] st_c;
   logic [31:0] rv_c;
   assign empty = (count_ff == '0);
   assign nocur = (cur_ff == NIL);
   assign full  = (free_top_ff == '0) && (fresh_ff == NIL);
   assign newn  = (free_top_ff != '0) ? {1'b0, fre_rdata} : fresh_ff;
   assign da = prv_rdata;
   assign db = nxt_rdata;

   always_comb begin
      st_c = cll_pkg::ST_OK;
      rv_c = '0;
      do_ins = 1'b0;
      do_del = 1'b0;
      ia = NIL;
      ib = NIL;
      unique case (func_ff)
         cll_pkg::FN_CLEAR: ;
         cll_pkg::FN_PREPEND: begin
            if (full) st_c = cll_pkg::ST_FULL;
            else begin do_ins = 1'b1; ia = NIL; ib = head_ff; end
         end
         cll_pkg::FN_APPEND: begin
            if (full) st_c = cll_pkg::ST_FULL;
            else begin do_ins = 1'b1; ia = tail_ff; ib = NIL; end
         end
         default: begin
            if (empty) st_c = cll_pkg::ST_EMPTY;
            else begin
               case (func_ff)
                  cll_pkg::FN_INSBEFORE, cll_pkg::FN_INSAFTER: begin
                     if (nocur) st_c = cll_pkg::ST_NOCUR;
                     else if (full) st_c = cll_pkg::ST_FULL;
                     else begin
                        do_ins = 1'b1;
                        if (func_ff == cll_pkg::FN_INSBEFORE) begin
                           ia = da; ib = cur_ff;
                        end else begin
                           ia = cur_ff; ib = db;
                        end
                     end
                  end
                  cll_pkg::FN_DELFRONT, cll_pkg::FN_DELBACK: do_del = 1'b1;
                  cll_pkg::FN_DELCURSOR, cll_pkg::FN_SET: begin
                     if (nocur) st_c = cll_pkg::ST_NOCUR;
                     else if (func_ff == cll_pkg::FN_DELCURSOR) do_del = 1'b1;
                  end
                  cll_pkg::FN_GET: begin
                     if (nocur) st_c = cll_pkg::ST_NOCUR;
                     else rv_c = val_rdata;
                  end
                  cll_pkg::FN_FRONT, cll_pkg::FN_BACK: rv_c = val_rdata;
                  default: ;
               endcase
            end
         end
      endcase
   end
   assign ok_ins = do_ins;

   // memory writes in execute; delete link writes go through d_*
   logic exec;
   logic          d_prv_e, d_nxt_e;
   logic [AW-1:0] d_prv_a, d_nxt_a;
   logic [AW:0]   d_prv_d, d_nxt_d;
   assign exec = (state_ff == S_EXEC);
   always_comb begin
      val_we = 1'b0; fre_we = 1'b0; d_prv_e = 1'b0; d_nxt_e = 1'b0;
      val_waddr = newn[AW-1:0]; val_wdata = value_ff;
      d_nxt_a = da[AW-1:0]; d_nxt_d = db;
      d_prv_a = db[AW-1:0]; d_prv_d = da;
      fre_waddr = free_top_ff[AW-1:0]; fre_wdata = focus[AW-1:0];
      if (exec && ok_ins) begin
         // new node takes its value here; links follow in the link phases
         val_we = 1'b1;
      end
      if (exec && func_ff == cll_pkg::FN_SET && st_c == cll_pkg::ST_OK && !empty) begin
         val_we = 1'b1; val_waddr = cur_ff[AW-1:0];
      end
      if (exec && do_del) begin
         fre_we = 1'b1;
         d_nxt_e = (da != NIL);
         d_prv_e = (db != NIL);
      end
   end

   // Inserts write their links in the link phases after execute.
   logic link_ff;
   logic [AW:0] lnew_ff, la_ff, lb_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         free_top_ff <= '0;
         fresh_ff    <= '0;
         head_ff     <= NIL;
         tail_ff     <= NIL;
         cur_ff      <= NIL;
         count_ff    <= '0;
         cidx_ff     <= '1;
         link_ff     <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: if (req_valid && req_ready) begin
               func_ff  <= cll_pkg::func_type'(req_func);
               value_ff <= req_value;
               state_ff <= S_READ;
            end
            S_READ: state_ff <= S_EXEC;
            S_EXEC: begin
               rv_ff <= rv_c;
               st_ff <= st_c;
               link_ff <= ok_ins;
               lnew_ff <= newn; la_ff <= ia; lb_ff <= ib;
               state_ff <= S_RESP;
               if (func_ff == cll_pkg::FN_CLEAR) begin
                  free_top_ff <= '0; fresh_ff <= '0; head_ff <= NIL;
                  tail_ff <= NIL; cur_ff <= NIL; count_ff <= '0; cidx_ff <= '1;
               end else if (ok_ins) begin
                  if (free_top_ff != '0) free_top_ff <= free_top_ff - 1'b1;
                  else fresh_ff <= fresh_ff + 1'b1;
                  count_ff <= count_ff + 1'b1;
                  if (ia == NIL) head_ff <= newn;
                  if (ib == NIL) tail_ff <= newn;
                  if ((func_ff == cll_pkg::FN_PREPEND && !nocur) ||
                      func_ff == cll_pkg::FN_INSBEFORE)
                     cidx_ff <= cidx_ff + 1'b1;
               end else if (do_del) begin
                  free_top_ff <= free_top_ff + 1'b1;
                  count_ff <= count_ff - 1'b1;
                  if (da == NIL) head_ff <= db;
                  if (db == NIL) tail_ff <= da;
                  if (cur_ff == focus) begin
                     cur_ff <= NIL; cidx_ff <= '1;
                  end else if (func_ff == cll_pkg::FN_DELFRONT && !nocur)
                     cidx_ff <= cidx_ff - 1'b1;
               end else if (st_c == cll_pkg::ST_OK && !empty) begin
                  case (func_ff)
                     cll_pkg::FN_MFRONT: begin cur_ff <= head_ff; cidx_ff <= '0; end
                     cll_pkg::FN_MBACK: begin
                        cur_ff <= tail_ff; cidx_ff <= $signed(count_ff - 1'b1);
                     end
                     cll_pkg::FN_PREV: if (!nocur) begin
                        if (cur_ff == head_ff) begin cur_ff <= NIL; cidx_ff <= '1; end
                        else begin cur_ff <= da; cidx_ff <= cidx_ff - 1'b1; end
                     end
                     cll_pkg::FN_NEXT: if (!nocur) begin
                        if (cur_ff == tail_ff) begin cur_ff <= NIL; cidx_ff <= '1; end
                        else begin cur_ff <= db; cidx_ff <= cidx_ff + 1'b1; end
                     end
                     default: ;
                  endcase
               end
            end
            S_RESP: begin
               link_ff <= 1'b0;
               if (rsp_valid && rsp_ready) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // Link write phases for inserts: new node's links and neighbour links.
   // The new node's prev/next are written here too (ports are free).
   logic [AW-1:0] lw_prv_a, lw_nxt_a;
   logic [AW:0]   lw_prv_d, lw_nxt_d;
   logic          lw_prv_e, lw_nxt_e;
   logic [1:0]    lphase_ff;
   always_ff @(posedge clock) begin
      if (reset) lphase_ff <= '0;
      else if (exec && ok_ins) lphase_ff <= 2'd1;
      else if (lphase_ff == 2'd1) lphase_ff <= 2'd2;
      else lphase_ff <= '0;
   end
   // phase 1: new node links; phase 2: neighbour links
   always_comb begin
      lw_prv_e = 1'b0; lw_nxt_e = 1'b0;
      lw_prv_a = lnew_ff[AW-1:0]; lw_nxt_a = lnew_ff[AW-1:0];
      lw_prv_d = la_ff; lw_nxt_d = lb_ff;
      if (lphase_ff == 2'd1) begin
         lw_prv_e = 1'b1; lw_nxt_e = 1'b1;
      end else if (lphase_ff == 2'd2) begin
         lw_nxt_e = (la_ff != NIL); lw_nxt_a = la_ff[AW-1:0]; lw_nxt_d = lnew_ff;
         lw_prv_e = (lb_ff != NIL); lw_prv_a = lb_ff[AW-1:0]; lw_prv_d = lnew_ff;
      end
   end

   // the delete writes come from execute; insert writes from the link phases
   logic [AW-1:0] m_prv_a, m_nxt_a;
   logic [AW:0]   m_prv_d, m_nxt_d;
   logic          m_prv_e, m_nxt_e;
   assign m_prv_e = d_prv_e | lw_prv_e;
   assign m_prv_a = d_prv_e ? d_prv_a : lw_prv_a;
   assign m_prv_d = d_prv_e ? d_prv_d : lw_prv_d;
   assign m_nxt_e = d_nxt_e | lw_nxt_e;
   assign m_nxt_a = d_nxt_e ? d_nxt_a : lw_nxt_a;
   assign m_nxt_d = d_nxt_e ? d_nxt_d : lw_nxt_d;
   assign prv_we = m_prv_e; assign prv_waddr = m_prv_a; assign prv_wdata = m_prv_d;
   assign nxt_we = m_nxt_e; assign nxt_waddr = m_nxt_a; assign nxt_wdata = m_nxt_d;

   // ready only after link phases drained
   logic busy_link;
   assign busy_link = (lphase_ff != 2'd0) || link_ff;

   assign req_ready = (state_ff == S_IDLE) && !busy_link;
   assign rsp_valid = (state_ff == S_RESP) && !busy_link;
   assign rsp_read_value = rv_ff;
   assign rsp_count      = 9'(count_ff);
   assign rsp_cursor_pos = 9'(cidx_ff);
   assign rsp_status     = st_ff;

   // Assertions
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (AW+1)'(CAPACITY)) else $error("count overflow");
   a_nocur_idx: assert property (@(posedge clock) disable iff (reset)
      (cur_ff == NIL) |-> (cidx_ff == '1)) else $error("index without cursor");
   a_empty_ends: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (head_ff == NIL && tail_ff == NIL))
      else $error("ends set on empty list");
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("ready during response");
endmodule

FILE: sim/cursor_linked_list_engine_core_tb.sv
// Testbench: directed table then random operations on the list engine, checked by a list model.
`timescale 1ns / 1ps
module cursor_linked_list_engine_core_tb;

   localparam int CAP = 256;
   localparam int NIL = CAP;
   localparam int CYCLE_LIMIT = 400000;
   localparam int N_RANDOM = 570;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [3:0] req_func = cll_pkg::FN_CLEAR;
   logic signed [31:0] req_value = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [31:0] rsp_read_value;
   logic [8:0] rsp_count;
   logic signed [8:0] rsp_cursor_pos;
   logic [1:0] rsp_status;

   cursor_linked_list_engine_core #(.CAPACITY(CAP)) u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_func(req_func), .req_value(req_value),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_read_value(rsp_read_value), .rsp_count(rsp_count),
      .rsp_cursor_pos(rsp_cursor_pos), .rsp_status(rsp_status)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   typedef struct packed {
      logic signed [31:0]  rdval;
      logic [8:0]          cnt;
      logic signed [8:0]   cpos;
      cll_pkg::status_type st;
   } list_reply;

   // model of the list: node pool, free stack, ends and cursor
   logic [31:0] m_val [CAP];
   int          m_prev [CAP];
   int          m_next [CAP];
   int          m_free [CAP];
   int m_free_top, m_fresh, m_head, m_tail, m_cur, m_len, m_cidx;

   list_reply expected_replies[$];
   int n_mismatch = 0;
   int n_checked = 0;
   int cycles = 0;
   bit hold_off = 1'b0;   // long receiver stall, driven from the stimulus process
   bit timed_out = 1'b0;

   function automatic void list_clear();
      m_free_top = 0; m_fresh = 0; m_head = NIL; m_tail = NIL;
      m_len = 0; m_cur = NIL; m_cidx = -1;
   endfunction

   function automatic int take_node();
      if (m_free_top > 0) begin
         m_free_top--;
         return m_free[m_free_top];
      end
      if (m_fresh < CAP) return m_fresh++;
      return NIL;
   endfunction

   function automatic void link_in(int n, int a, int b, logic [31:0] v);
      m_val[n] = v; m_prev[n] = a; m_next[n] = b;
      if (a != NIL) m_next[a] = n; else m_head = n;
      if (b != NIL) m_prev[b] = n; else m_tail = n;
      m_len++;
   endfunction

   function automatic void unlink(int p);
      int a, b;
      a = m_prev[p];
      b = m_next[p];
      if (a != NIL) m_next[a] = b; else m_head = b;
      if (b != NIL) m_prev[b] = a; else m_tail = a;
      if (m_cur == p) begin
         m_cur = NIL; m_cidx = -1;
      end
      m_free[m_free_top] = p;
      m_free_top++;
      m_len--;
   endfunction

   // apply one operation to the model and return the reply it causes
   function automatic list_reply list_apply(cll_pkg::func_type f, logic [31:0] v);
      list_reply r;
      int n;
      bit nocur;
      r.rdval = '0;
      r.st = cll_pkg::ST_OK;
      nocur = (m_cur == NIL);
      if (f == cll_pkg::FN_CLEAR) list_clear();
      else if (f == cll_pkg::FN_PREPEND || f == cll_pkg::FN_APPEND) begin
         n = take_node();
         if (n == NIL) r.st = cll_pkg::ST_FULL;
         else if (f == cll_pkg::FN_PREPEND) begin
            link_in(n, NIL, m_head, v);
            if (!nocur) m_cidx++;
         end else link_in(n, m_tail, NIL, v);
      end else if (m_len == 0) r.st = cll_pkg::ST_EMPTY;
      else begin
         case (f)
            cll_pkg::FN_MFRONT: begin m_cur = m_head; m_cidx = 0; end
            cll_pkg::FN_MBACK:  begin m_cur = m_tail; m_cidx = m_len - 1; end
            cll_pkg::FN_PREV: if (!nocur) begin
               if (m_cur == m_head) begin m_cur = NIL; m_cidx = -1; end
               else begin m_cur = m_prev[m_cur]; m_cidx--; end
            end
            cll_pkg::FN_NEXT: if (!nocur) begin
               if (m_cur == m_tail) begin m_cur = NIL; m_cidx = -1; end
               else begin m_cur = m_next[m_cur]; m_cidx++; end
            end
            cll_pkg::FN_INSBEFORE, cll_pkg::FN_INSAFTER: begin
               if (nocur) r.st = cll_pkg::ST_NOCUR;
               else begin
                  n = take_node();
                  if (n == NIL) r.st = cll_pkg::ST_FULL;
                  else if (f == cll_pkg::FN_INSBEFORE) begin
                     link_in(n, m_prev[m_cur], m_cur, v);
                     m_cidx++;
                  end else link_in(n, m_cur, m_next[m_cur], v);
               end
            end
            cll_pkg::FN_DELFRONT: begin
               if (!nocur && m_cur != m_head) m_cidx--;
               unlink(m_head);
            end
            cll_pkg::FN_DELBACK: unlink(m_tail);
            cll_pkg::FN_DELCURSOR: if (nocur) r.st = cll_pkg::ST_NOCUR; else unlink(m_cur);
            cll_pkg::FN_SET: if (nocur) r.st = cll_pkg::ST_NOCUR; else m_val[m_cur] = v;
            cll_pkg::FN_GET: if (nocur) r.st = cll_pkg::ST_NOCUR; else r.rdval = m_val[m_cur];
            cll_pkg::FN_FRONT: r.rdval = m_val[m_head];
            default: r.rdval = m_val[m_tail];
         endcase
      end
      r.cnt = m_len[8:0];
      r.cpos = m_cidx[8:0];
      return r;
   endfunction

   // directed rows: expectation typed in where obvious, else taken from the model
   typedef struct {
      cll_pkg::func_type f;
      logic [31:0]       v;
      bit                typed;
      list_reply         r;
   } stim_row;

   stim_row dir_rows[$];

   function automatic void add_row(cll_pkg::func_type f, logic [31:0] v, bit typed,
                                   logic [31:0] rv, int cnt, int cp,
                                   cll_pkg::status_type st);
      stim_row s;
      s.f = f; s.v = v; s.typed = typed;
      s.r.rdval = rv; s.r.cnt = cnt[8:0]; s.r.cpos = cp[8:0]; s.r.st = st;
      dir_rows.push_back(s);
   endfunction

   // sender: wait a drawn gap, offer the item, hold until accepted;
   // valid stays up after acceptance only when the next item follows at once
   task automatic send_item(cll_pkg::func_type f, logic [31:0] v, int gap);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= f;
      req_value <= v;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic issue(cll_pkg::func_type f, logic [31:0] v, bit typed, list_reply tr);
      list_reply r;
      r = list_apply(f, v);
      if (typed && r !== tr) begin
         n_mismatch++;
         if (n_mismatch <= 10)
            $display("typed row disagrees with model: func %s", f.name());
      end
      expected_replies.push_back(typed ? tr : r);
      send_item(f, v, $urandom_range(0, 4));
   endtask

   task automatic drain_wait();
      req_valid <= 1'b0;
      while (expected_replies.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   // checker: compare every accepted reply with the oldest expectation
   always @(posedge clock) begin
      list_reply want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_replies.size() == 0) begin
            n_mismatch++;
            if (n_mismatch <= 10) $display("unexpected reply item");
         end else begin
            want = expected_replies.pop_front();
            n_checked++;
            if (rsp_read_value !== want.rdval || rsp_count !== want.cnt ||
                rsp_cursor_pos !== want.cpos || rsp_status !== want.st) begin
               n_mismatch++;
               if (n_mismatch <= 10)
                  $display("mismatch: exp val %0d cnt %0d cur %0d st %0d, got %0d %0d %0d %0d",
                           want.rdval, want.cnt, want.cpos, want.st, rsp_read_value,
                           rsp_count, rsp_cursor_pos, rsp_status);
            end
         end
      end
   end

   // receiver: random short stalls, or a long hold-off on request
   initial begin
      int w;
      @(negedge reset);
      forever begin
         w = $urandom_range(0, 4);
         if (hold_off) begin
            rsp_ready <= 1'b0;
            repeat (60) @(posedge clock);
         end else if (w != 0 && ($urandom_range(0, 3) != 0)) begin
            rsp_ready <= 1'b0;
            repeat (w) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!(rsp_valid && rsp_ready)) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT && !timed_out) begin
         timed_out = 1'b1;
         $display("timeout after %0d cycles", cycles);
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      int k, fsel, nfull;
      cll_pkg::func_type f;
      logic [31:0] v;
      list_reply none;
      none = '0;
      list_clear();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty list cases, extremes of value, cursor edges, errors
      add_row(cll_pkg::FN_FRONT,     0, 1, 0, 0, -1, cll_pkg::ST_EMPTY);
      add_row(cll_pkg::FN_MFRONT,    0, 1, 0, 0, -1, cll_pkg::ST_EMPTY);
      add_row(cll_pkg::FN_DELBACK,   0, 1, 0, 0, -1, cll_pkg::ST_EMPTY);
      add_row(cll_pkg::FN_CLEAR,     0, 1, 0, 0, -1, cll_pkg::ST_OK);
      add_row(cll_pkg::FN_APPEND,    32'h7FFF_FFFF, 1, 0, 1, -1, cll_pkg::ST_OK);
      add_row(cll_pkg::FN_PREPEND,   32'h8000_0000, 1, 0, 2, -1, cll_pkg::ST_OK);
      add_row(cll_pkg::FN_GET,       0, 1, 0, 2, -1, cll_pkg::ST_NOCUR);
      add_row(cll_pkg::FN_INSBEFORE, 5, 1, 0, 2, -1, cll_pkg::ST_NOCUR);
      add_row(cll_pkg::FN_NEXT,      0, 1, 0, 2, -1, cll_pkg::ST_OK);
      add_row(cll_pkg::FN_FRONT,     0, 1, 32'h8000_0000, 2, -1, cll_pkg::ST_OK);
      add_row(cll_pkg::FN_BACK,      0, 1, 32'h7FFF_FFFF, 2, -1, cll_pkg::ST_OK);
      add_row(cll_pkg::FN_MFRONT,    0, 1, 0, 2, 0, cll_pkg::ST_OK);
      add_row(cll_pkg::FN_PREV,      0, 1, 0, 2, -1, cll_pkg::ST_OK);
      add_row(cll_pkg::FN_MBACK,     0, 1, 0, 2, 1, cll_pkg::ST_OK);
      add_row(cll_pkg::FN_NEXT,      0, 1, 0, 2, -1, cll_pkg::ST_OK);
      add_row(cll_pkg::FN_MBACK,     0, 0, 0, 0, 0, cll_pkg::ST_OK);
      add_row(cll_pkg::FN_INSBEFORE, 32'hFFFF_FFFF, 0, 0, 0, 0, cll_pkg::ST_OK);
      add_row(cll_pkg::FN_INSAFTER,  32'h5555_AAAA, 0, 0, 0, 0, cll_pkg::ST_OK);
      add_row(cll_pkg::FN_SET,       32'hAAAA_5555, 0, 0, 0, 0, cll_pkg::ST_OK);
      add_row(cll_pkg::FN_GET,       0, 0, 0, 0, 0, cll_pkg::ST_OK);
      add_row(cll_pkg::FN_PREPEND,   1, 0, 0, 0, 0, cll_pkg::ST_OK);
      add_row(cll_pkg::FN_DELFRONT,  0, 0, 0, 0, 0, cll_pkg::ST_OK);
      add_row(cll_pkg::FN_DELCURSOR, 0, 0, 0, 0, 0, cll_pkg::ST_OK);
      add_row(cll_pkg::FN_DELCURSOR, 0, 1, 0, 3, -1, cll_pkg::ST_NOCUR);
      add_row(cll_pkg::FN_CLEAR,     0, 1, 0, 0, -1, cll_pkg::ST_OK);
      foreach (dir_rows[i]) issue(dir_rows[i].f, dir_rows[i].v, dir_rows[i].typed,
                                  dir_rows[i].r);
      drain_wait();

      // fill the pool to the brim, the receiver holding off for the first 40 appends, then hit the full cases
      hold_off = 1'b1;
      for (k = 0; k < 40; k++) issue(cll_pkg::FN_APPEND, $urandom, 0, none);
      hold_off = 1'b0;
      for (k = 0; k < CAP - 40; k++) issue(cll_pkg::FN_PREPEND, $urandom, 0, none);
      issue(cll_pkg::FN_MFRONT, 0, 0, none);
      issue(cll_pkg::FN_APPEND, 0, 1, '{0, 9'd256, 9'd0, cll_pkg::ST_FULL});
      issue(cll_pkg::FN_INSAFTER, 0, 1, '{0, 9'd256, 9'd0, cll_pkg::ST_FULL});
      issue(cll_pkg::FN_PREPEND, 0, 0, none);
      issue(cll_pkg::FN_INSBEFORE, 0, 0, none);
      for (k = 0; k < 30; k++) issue(cll_pkg::FN_DELCURSOR, 0, 0, none);
      for (k = 0; k < 20; k++) issue(cll_pkg::FN_DELBACK, 0, 0, none);
      // sender pause: let every reply come home
      drain_wait();
      issue(cll_pkg::FN_CLEAR, 0, 0, none);

      // random: mostly builds and walks with random content; deletes are rarer than inserts
      nfull = 0;
      for (k = 0; k < N_RANDOM; k++) begin
         fsel = $urandom_range(0, 99);
         if (fsel < 2) f = cll_pkg::FN_CLEAR;
         else if (fsel < 40) f = cll_pkg::func_type'($urandom_range(5, 8));
         else if (fsel < 60) f = cll_pkg::func_type'($urandom_range(1, 4));
         else if (fsel < 75) f = cll_pkg::func_type'($urandom_range(9, 11));
         else f = cll_pkg::func_type'($urandom_range(12, 15));
         case ($urandom_range(0, 3))
            0: v = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            1: v = $urandom_range(0, 15) - 8;
            default: v = $urandom;
         endcase
         issue(f, v, 0, none);
         if (m_len == CAP) nfull++;
      end

      req_valid <= 1'b0;
      while (expected_replies.size() != 0 && !timed_out) @(posedge clock);
      repeat (10) @(posedge clock);
      $display("covered %0d checked replies: empty, no-cursor and full-pool cases,", n_checked);
      $display("cursor walks off both ends, deletes under the cursor, long output stall, %0d %s",
               nfull, "random steps at a full pool");
      if (n_mismatch == 0 && expected_replies.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("%0d mismatches, %0d replies missing", n_mismatch, expected_replies.size());
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
